>>> sv/bf_pkg.sv
// Shared types, constants and helpers for the flock update core.
`default_nettype none
package bf_pkg;

  localparam int IN_W  = 312;
  localparam int OUT_W = 200;
  localparam int CFG_W = 31;

  localparam logic [2:0] CFG_RADIUS    = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED = 3'd1;
  localparam logic [2:0] CFG_MAX_FORCE = 3'd2;
  localparam logic [2:0] CFG_W_COH     = 3'd3;
  localparam logic [2:0] CFG_W_ALI     = 3'd4;
  localparam logic [2:0] CFG_W_SEP     = 3'd5;
  localparam logic [2:0] CFG_W_TGT     = 3'd6;
  localparam logic [2:0] CFG_COUNT     = 3'd7;

  localparam logic signed [33:0] SAT_HI = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_LO = 34'sh3_8000_0000;

  typedef enum logic [2:0] {
    VM_NORM  = 3'b001,
    VM_CLAMP = 3'b010,
    VM_TEST  = 3'b100
  } vec_mode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } agent_t;

  function automatic logic [47:0] mag48(input logic signed [47:0] a);
    return a[47] ? 48'(-a) : 48'(a);
  endfunction

  function automatic logic signed [47:0] sgn48(input logic [47:0] m, input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] a);
    logic signed [31:0] r;
    if (a > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (a < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/bf_mul.sv
// Shared registered unsigned multiplier.
`default_nettype none
module bf_mul (
  input  wire logic        clk,
  input  wire logic [32:0] a,
  input  wire logic [30:0] b,
  output logic      [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule
`default_nettype wire

>>> sv/bf_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module bf_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic        [63:0] num,
  input  wire logic        [31:0] den,
  output logic             [63:0] quot,
  output bf_pkg::unit_stat_t      stat
);

  logic [31:0] rem;
  logic [31:0] dv;
  logic [6:0]  cnt;
  logic [32:0] sh;

  assign sh = {rem, quot[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else if (start) begin
      quot      <= num;
      dv        <= den;
      rem       <= '0;
      cnt       <= 7'd64;
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
    end else if (stat.busy) begin
      if (sh >= {1'b0, dv}) begin
        rem  <= 32'(sh - {1'b0, dv});
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem  <= sh[31:0];
        quot <= {quot[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/bf_sqrt.sv
// Shared integer square root, one result bit per cycle.
`default_nettype none
module bf_sqrt (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic        [63:0] x,
  output logic             [31:0] root,
  output bf_pkg::unit_stat_t      stat
);

  logic [63:0] rn;
  logic [63:0] rr;
  logic [63:0] bt;
  logic [63:0] trial;

  assign trial = rr + bt;
  assign root  = rr[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else if (start) begin
      rn        <= x;
      rr        <= '0;
      bt        <= 64'h4000_0000_0000_0000;
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
    end else if (stat.busy) begin
      if (rn >= trial) begin
        rn <= rn - trial;
        rr <= (rr >> 1) + bt;
      end else begin
        rr <= rr >> 1;
      end
      bt <= bt >> 2;
      if (bt == 64'd1) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/boids_flock_update_step_core.sv
// Top level of the flock update core: agent store, sequencer and shared units.
//
// Input channel s_*: one request per handshake. s_tuser low loads one agent
// (index, position, velocity) into the store; s_tuser high runs one tick with
// the goal point and time step. The block takes a request only when idle.
// Output channel m_*: a tick returns one result per agent 0..n-1, in order,
// with m_tlast on the final one; a load or a tick with n = 0 returns nothing.
// Configuration: cfg_we writes cfg_data into the register cfg_index.
// Every agent pass runs through one multiplier, one divider and one square root
// under a single sequencer. A neighbor pair costs two divisions per axis, and
// each agent adds the means, steering and clamping work.
// A result holds on m_* until taken; the sequencer waits meanwhile, so a
// stalled receiver stalls the tick. Reset returns to idle with the output
// empty and the registers at their defaults; the agent store is not cleared.
`default_nettype none
module boids_flock_update_step_core #(
  parameter int MAX_AGENTS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // agent_index, load_pos_x/y/z, load_vel_x/y/z, goal_x/y/z, delta_time, zero pad
  input  wire logic [bf_pkg::IN_W-1:0]   s_tdata,
  // req_type
  input  wire logic                      s_tuser,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // out_index, out_pos_x/y/z, out_vel_x/y/z, zero pad
  output logic [bf_pkg::OUT_W-1:0]       m_tdata,
  output logic                           m_tlast,
  input  wire logic                      cfg_we,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [bf_pkg::CFG_W-1:0]  cfg_data
);

  localparam int AW  = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int CAP = (MAX_AGENTS < 16) ? MAX_AGENTS : 16;
  localparam logic [4:0] NCAP = 5'(CAP);

  typedef enum logic [36:0] {
    ST_IDLE   = 37'd1 << 0,
    ST_RDI    = 37'd1 << 1,
    ST_RDIW   = 37'd1 << 2,
    ST_RDJ    = 37'd1 << 3,
    ST_RDJW   = 37'd1 << 4,
    ST_ACC    = 37'd1 << 5,
    ST_NEXTJ  = 37'd1 << 6,
    ST_MDIV   = 37'd1 << 7,
    ST_MDIVW  = 37'd1 << 8,
    ST_ALI    = 37'd1 << 9,
    ST_ALI2   = 37'd1 << 10,
    ST_ST0    = 37'd1 << 11,
    ST_ST2    = 37'd1 << 12,
    ST_ST3    = 37'd1 << 13,
    ST_ST4    = 37'd1 << 14,
    ST_ST5    = 37'd1 << 15,
    ST_WGT0   = 37'd1 << 16,
    ST_WGT    = 37'd1 << 17,
    ST_WGTA   = 37'd1 << 18,
    ST_VCL    = 37'd1 << 19,
    ST_POS    = 37'd1 << 20,
    ST_POSA   = 37'd1 << 21,
    ST_WB     = 37'd1 << 22,
    ST_OUTW   = 37'd1 << 23,
    V_MAG     = 37'd1 << 24,
    V_SHIFT   = 37'd1 << 25,
    V_SQ      = 37'd1 << 26,
    V_SQACC   = 37'd1 << 27,
    V_LIM     = 37'd1 << 28,
    V_LIMCMP  = 37'd1 << 29,
    V_SQRT    = 37'd1 << 30,
    V_SQRTW   = 37'd1 << 31,
    V_COMP    = 37'd1 << 32,
    V_CDIV    = 37'd1 << 33,
    V_DIVW    = 37'd1 << 34,
    V_DIV2    = 37'd1 << 35,
    V_DIV2W   = 37'd1 << 36
  } state_t;

  state_t state;
  state_t vret;

  logic [30:0] radius;
  logic [30:0] max_speed;
  logic [30:0] max_force;
  logic [15:0] w_coh;
  logic [15:0] w_ali;
  logic [15:0] w_sep;
  logic [15:0] w_tgt;
  logic [4:0]  member_count;

  logic signed [31:0] goal [3];
  logic [15:0]        dt;
  logic [4:0]         n;
  logic [4:0]         i;
  logic [4:0]         j;
  logic [4:0]         cnt;
  logic [3:0]         idx;
  logic [1:0]         wt;
  logic [1:0]         vk;
  logic               steer_goal;

  logic signed [31:0] p  [3];
  logic signed [31:0] v  [3];
  logic signed [31:0] qp [3];
  logic signed [31:0] qw [3];
  logic signed [47:0] trm [12];

  logic signed [47:0] vv [3];
  logic        [47:0] mg [3];
  logic               ng [3];
  logic signed [47:0] st [3];
  logic               shifted;
  logic        [63:0] sum;
  logic        [31:0] len;
  bf_pkg::vec_mode_t  vmode;
  logic        [30:0] vlim;
  logic               nb;

  logic [3:0] out_idx;
  logic signed [31:0] out_p [3];
  logic signed [31:0] out_v [3];

  bf_pkg::agent_t mem [MAX_AGENTS];
  bf_pkg::agent_t rd;
  bf_pkg::agent_t wdata;
  logic           mem_we;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;

  logic [32:0] mul_a;
  logic [30:0] mul_b;
  logic [63:0] mul_p;
  logic        div_go;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic [63:0] dq;
  bf_pkg::unit_stat_t dstat;
  logic        sq_go;
  logic [31:0] root;
  bf_pkg::unit_stat_t sstat;

  logic [47:0] magv;
  logic [47:0] magt;
  logic [15:0] wsel;
  logic [3:0]  ld_idx;
  logic [4:0]  n_eff;
  logic        ld_ok;

  bf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  bf_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_num), .den(div_den),
    .quot(dq), .stat(dstat)
  );

  bf_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_go), .x(sum), .root(root), .stat(sstat)
  );

  assign s_tready = (state == ST_IDLE);
  assign ld_idx   = s_tdata[3:0];
  assign ld_ok    = (32'(ld_idx) < MAX_AGENTS);
  assign n_eff    = (member_count > NCAP) ? NCAP : member_count;
  assign m_tdata  = {4'b0, out_v[2], out_v[1], out_v[0], out_p[2], out_p[1], out_p[0],
                     out_idx};

  assign magv = bf_pkg::mag48(vv[vk]);
  assign magt = bf_pkg::mag48(trm[idx]);

  always_comb begin
    case (wt)
      2'd0:    wsel = w_coh;
      2'd1:    wsel = w_ali;
      2'd2:    wsel = w_sep;
      default: wsel = w_tgt;
    endcase
  end

  always_comb begin
    raddr = (state == ST_RDI) ? AW'(i) : AW'(j);
    mem_we = 1'b0;
    waddr  = AW'(i);
    wdata  = '{vel_z: vv[2][31:0], vel_y: vv[1][31:0], vel_x: vv[0][31:0],
               pos_z: p[2], pos_y: p[1], pos_x: p[0]};
    if (state == ST_IDLE) begin
      mem_we = s_tvalid && !s_tuser && ld_ok;
      waddr  = AW'(ld_idx);
      wdata  = '{vel_z: s_tdata[195:164], vel_y: s_tdata[163:132], vel_x: s_tdata[131:100],
                 pos_z: s_tdata[99:68], pos_y: s_tdata[67:36], pos_x: s_tdata[35:4]};
    end else if (state == ST_WB) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_go  = 1'b0;
    div_num = '0;
    div_den = len;
    sq_go   = 1'b0;
    case (state)
      V_SQ: begin
        mul_a = 33'(mg[vk][30:0]);
        mul_b = mg[vk][30:0];
      end
      V_LIM: begin
        mul_a = 33'(vlim);
        mul_b = vlim;
      end
      V_COMP: begin
        if (vmode == bf_pkg::VM_CLAMP) begin
          mul_a = 33'(mg[vk][30:0]);
          mul_b = vlim;
        end else if (len != 32'd0) begin
          div_go  = 1'b1;
          div_num = 64'(mg[vk]) << 16;
        end
      end
      V_CDIV: begin
        div_go  = 1'b1;
        div_num = mul_p;
      end
      V_DIV2: begin
        div_go  = 1'b1;
        div_num = {dq[47:0], 16'b0};
      end
      V_SQRT: sq_go = 1'b1;
      ST_ST2: begin
        mul_a = magv[32:0];
        mul_b = max_speed;
      end
      ST_MDIV: begin
        div_go  = 1'b1;
        div_num = 64'(magt);
        div_den = 32'(cnt);
      end
      ST_WGT: begin
        mul_a = magt[32:0];
        mul_b = 31'(wsel);
      end
      ST_POS: begin
        mul_a = magv[32:0];
        mul_b = 31'(dt);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      radius       <= 31'd6553600;
      max_speed    <= 31'd13107200;
      max_force    <= 31'd655360;
      w_coh        <= 16'd256;
      w_ali        <= 16'd256;
      w_sep        <= 16'd256;
      w_tgt        <= 16'd256;
      member_count <= 5'd0;
      vk           <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bf_pkg::CFG_RADIUS:    radius       <= cfg_data;
          bf_pkg::CFG_MAX_SPEED: max_speed    <= cfg_data;
          bf_pkg::CFG_MAX_FORCE: max_force    <= cfg_data;
          bf_pkg::CFG_W_COH:     w_coh        <= cfg_data[15:0];
          bf_pkg::CFG_W_ALI:     w_ali        <= cfg_data[15:0];
          bf_pkg::CFG_W_SEP:     w_sep        <= cfg_data[15:0];
          bf_pkg::CFG_W_TGT:     w_tgt        <= cfg_data[15:0];
          bf_pkg::CFG_COUNT:     member_count <= cfg_data[4:0];
          default:               member_count <= member_count;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tuser) begin
            goal[0] <= s_tdata[227:196];
            goal[1] <= s_tdata[259:228];
            goal[2] <= s_tdata[291:260];
            dt      <= s_tdata[307:292];
            n       <= n_eff;
            i       <= 5'd0;
            if (n_eff != 5'd0) begin
              state <= ST_RDI;
            end
          end
        end
        ST_RDI: state <= ST_RDIW;
        ST_RDIW: begin
          p[0] <= rd.pos_x;
          p[1] <= rd.pos_y;
          p[2] <= rd.pos_z;
          v[0] <= rd.vel_x;
          v[1] <= rd.vel_y;
          v[2] <= rd.vel_z;
          for (int t = 0; t < 12; t++) begin
            trm[t] <= '0;
          end
          cnt   <= 5'd0;
          j     <= 5'd0;
          state <= ST_RDJ;
        end
        ST_RDJ: state <= ST_RDJW;
        ST_RDJW: begin
          qp[0] <= rd.pos_x;
          qp[1] <= rd.pos_y;
          qp[2] <= rd.pos_z;
          qw[0] <= rd.vel_x;
          qw[1] <= rd.vel_y;
          qw[2] <= rd.vel_z;
          vv[0] <= 48'(p[0]) - 48'(rd.pos_x);
          vv[1] <= 48'(p[1]) - 48'(rd.pos_y);
          vv[2] <= 48'(p[2]) - 48'(rd.pos_z);
          vmode <= bf_pkg::VM_TEST;
          vlim  <= radius;
          vret  <= ST_ACC;
          state <= V_MAG;
        end
        ST_ACC: begin
          if (nb) begin
            for (int k = 0; k < 3; k++) begin
              trm[k]     <= trm[k] + 48'(qp[k]);
              trm[3 + k] <= trm[3 + k] + 48'(qw[k]);
              trm[6 + k] <= trm[6 + k] + st[k];
            end
            cnt <= cnt + 5'd1;
          end
          j     <= j + 5'd1;
          state <= ST_NEXTJ;
        end
        ST_NEXTJ: begin
          if (j == n) begin
            if (cnt == 5'd0) begin
              steer_goal <= 1'b1;
              state      <= ST_ST0;
            end else begin
              idx   <= 4'd0;
              state <= ST_MDIV;
            end
          end else begin
            state <= ST_RDJ;
          end
        end
        ST_MDIV: state <= ST_MDIVW;
        ST_MDIVW: begin
          if (dstat.done) begin
            trm[idx] <= bf_pkg::sgn48(dq[47:0], trm[idx][47]);
            if (idx == 4'd8) begin
              steer_goal <= 1'b0;
              state      <= ST_ST0;
            end else begin
              idx   <= idx + 4'd1;
              state <= ST_MDIV;
            end
          end
        end
        ST_ALI: begin
          vv[0] <= trm[3];
          vv[1] <= trm[4];
          vv[2] <= trm[5];
          vmode <= bf_pkg::VM_CLAMP;
          vlim  <= max_force;
          vret  <= ST_ALI2;
          state <= V_MAG;
        end
        ST_ALI2: begin
          trm[3]     <= vv[0];
          trm[4]     <= vv[1];
          trm[5]     <= vv[2];
          steer_goal <= 1'b1;
          state      <= ST_ST0;
        end
        ST_ST0: begin
          for (int k = 0; k < 3; k++) begin
            vv[k] <= (steer_goal ? 48'(goal[k]) : trm[k]) - 48'(p[k]);
          end
          vmode <= bf_pkg::VM_NORM;
          vret  <= ST_ST2;
          state <= V_MAG;
        end
        ST_ST2: state <= ST_ST3;
        ST_ST3: begin
          vv[vk] <= bf_pkg::sgn48(48'(mul_p >> 16), vv[vk][47]) - 48'(v[vk]);
          if (vk == 2'd2) begin
            vk    <= 2'd0;
            state <= ST_ST4;
          end else begin
            vk    <= vk + 2'd1;
            state <= ST_ST2;
          end
        end
        ST_ST4: begin
          vmode <= bf_pkg::VM_CLAMP;
          vlim  <= max_force;
          vret  <= ST_ST5;
          state <= V_MAG;
        end
        ST_ST5: begin
          if (steer_goal) begin
            trm[9]  <= vv[0];
            trm[10] <= vv[1];
            trm[11] <= vv[2];
            state   <= ST_WGT0;
          end else begin
            trm[0] <= vv[0];
            trm[1] <= vv[1];
            trm[2] <= vv[2];
            state  <= ST_ALI;
          end
        end
        ST_WGT0: begin
          for (int k = 0; k < 3; k++) begin
            vv[k] <= 48'(v[k]);
          end
          wt    <= 2'd0;
          vk    <= 2'd0;
          idx   <= 4'd0;
          state <= ST_WGT;
        end
        ST_WGT: state <= ST_WGTA;
        ST_WGTA: begin
          vv[vk] <= vv[vk] + bf_pkg::sgn48(48'(mul_p >> 8), trm[idx][47]);
          idx    <= idx + 4'd1;
          state  <= ST_WGT;
          if (vk == 2'd2) begin
            vk <= 2'd0;
            if (wt == 2'd3) begin
              state <= ST_VCL;
            end else begin
              wt <= wt + 2'd1;
            end
          end else begin
            vk <= vk + 2'd1;
          end
        end
        ST_VCL: begin
          vmode <= bf_pkg::VM_CLAMP;
          vlim  <= max_speed;
          vret  <= ST_POS;
          state <= V_MAG;
        end
        ST_POS: state <= ST_POSA;
        ST_POSA: begin
          p[vk] <= bf_pkg::sat32(34'(p[vk]) +
                   34'(bf_pkg::sgn48(48'(mul_p >> 16), vv[vk][47])));
          if (vk == 2'd2) begin
            vk    <= 2'd0;
            state <= ST_WB;
          end else begin
            vk    <= vk + 2'd1;
            state <= ST_POS;
          end
        end
        ST_WB: begin
          out_idx  <= i[3:0];
          for (int k = 0; k < 3; k++) begin
            out_p[k] <= p[k];
            out_v[k] <= vv[k][31:0];
          end
          m_tlast  <= (i + 5'd1 == n);
          m_tvalid <= 1'b1;
          state    <= ST_OUTW;
        end
        ST_OUTW: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= ST_IDLE;
            end else begin
              i     <= i + 5'd1;
              state <= ST_RDI;
            end
          end
        end
        V_MAG: begin
          for (int k = 0; k < 3; k++) begin
            mg[k] <= bf_pkg::mag48(vv[k]);
            ng[k] <= vv[k][47];
          end
          shifted <= 1'b0;
          sum     <= '0;
          vk      <= 2'd0;
          state   <= V_SHIFT;
        end
        V_SHIFT: begin
          if ((|mg[0][47:31]) || (|mg[1][47:31]) || (|mg[2][47:31])) begin
            for (int k = 0; k < 3; k++) begin
              mg[k] <= mg[k] >> 1;
            end
            shifted <= 1'b1;
          end else begin
            state <= V_SQ;
          end
        end
        V_SQ: state <= V_SQACC;
        V_SQACC: begin
          sum <= sum + mul_p;
          if (vk == 2'd2) begin
            vk    <= 2'd0;
            state <= (vmode == bf_pkg::VM_NORM) ? V_SQRT : V_LIM;
          end else begin
            vk    <= vk + 2'd1;
            state <= V_SQ;
          end
        end
        V_LIM: state <= V_LIMCMP;
        V_LIMCMP: begin
          if (vmode == bf_pkg::VM_CLAMP) begin
            state <= (!shifted && sum <= mul_p) ? vret : V_SQRT;
          end else if (shifted || sum == 64'd0 || sum >= mul_p) begin
            nb    <= 1'b0;
            state <= vret;
          end else begin
            nb    <= 1'b1;
            state <= V_SQRT;
          end
        end
        V_SQRT: state <= V_SQRTW;
        V_SQRTW: begin
          if (sstat.done) begin
            len   <= root;
            state <= V_COMP;
          end
        end
        V_COMP: begin
          if (vmode == bf_pkg::VM_CLAMP) begin
            state <= V_CDIV;
          end else if (len != 32'd0) begin
            state <= V_DIVW;
          end else begin
            vv[vk] <= '0;
            if (vk == 2'd2) begin
              vk    <= 2'd0;
              state <= vret;
            end else begin
              vk <= vk + 2'd1;
            end
          end
        end
        V_CDIV: state <= V_DIVW;
        V_DIVW: begin
          if (dstat.done) begin
            if (vmode == bf_pkg::VM_TEST) begin
              state <= V_DIV2;
            end else begin
              vv[vk] <= bf_pkg::sgn48(dq[47:0], ng[vk]);
              if (vk == 2'd2) begin
                vk    <= 2'd0;
                state <= vret;
              end else begin
                vk    <= vk + 2'd1;
                state <= V_COMP;
              end
            end
          end
        end
        V_DIV2: state <= V_DIV2W;
        V_DIV2W: begin
          if (dstat.done) begin
            st[vk] <= bf_pkg::sgn48(dq[47:0], ng[vk]);
            if (vk == 2'd2) begin
              vk    <= 2'd0;
              state <= vret;
            end else begin
              vk    <= vk + 2'd1;
              state <= V_COMP;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/bf_check.sv
// Port-level checks for the flock update core, bound to the top level.
`default_nettype none
module bf_check (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_tready,
  input wire logic                     m_tvalid,
  input wire logic                     m_tready,
  input wire logic [bf_pkg::OUT_W-1:0] m_tdata,
  input wire logic                     m_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request taken while a result is pending");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready after final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> !s_tready)
    else $error("ready in the middle of a tick");

endmodule

bind boids_flock_update_step_core bf_check u_check (.*);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the flock update core: directed and random requests vs. a predictor.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint s64;
  typedef longint unsigned u64;
  typedef s64 vec_t [3];
  typedef logic [7:0][31:0] agent_res_t;

  typedef struct {
    bit         tick;
    bit [3:0]   idx;
    int         lp[3];
    int         lv[3];
    int         goal[3];
    bit [15:0]  dt;
  } flock_req_t;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [bf_pkg::IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [bf_pkg::OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = bf_pkg::CFG_RADIUS;
  logic [bf_pkg::CFG_W-1:0] cfg_data = '0;

  boids_flock_update_step_core #(.MAX_AGENTS(NSLOT)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // register mirror
  u64 radius, speed, force_lim, w_coh, w_ali, w_sep, w_tgt, count;
  int pos_st[NSLOT][3];
  int vel_st[NSLOT][3];

  agent_res_t agent_q[$];
  int errors = 0;
  int src_idle = 0;
  int snk_stall = 0;
  int hold_left = 0;
  int n_loads = 0, n_ticks = 0, n_results = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic u64 mag(s64 a);
    return a < 0 ? u64'(-a) : u64'(a);
  endfunction

  function automatic s64 sgn(u64 m, bit neg);
    return neg ? -s64'(m) : s64'(m);
  endfunction

  function automatic u64 isqrt(u64 n);
    u64 r, b;
    r = 0;
    b = u64'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int unsigned prescale(input vec_t a, output u64 m[3], output u64 sum);
    u64 mx;
    int unsigned s;
    mx = 0;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = mag(a[k]);
      if (m[k] > mx) mx = m[k];
    end
    while ((mx >> s) >= 64'h8000_0000) s++;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] >>= s;
      sum += m[k] * m[k];
    end
    return s;
  endfunction

  function automatic void unit_of(input vec_t a, output vec_t o);
    u64 m[3];
    u64 sum, len;
    void'(prescale(a, m, sum));
    len = isqrt(sum);
    for (int k = 0; k < 3; k++) o[k] = (len == 0) ? 0 : sgn((m[k] << 16) / len, a[k] < 0);
  endfunction

  function automatic void clamp_len(inout vec_t a, input u64 lim);
    u64 m[3];
    u64 sum, len;
    int unsigned s;
    s = prescale(a, m, sum);
    if (s == 0 && sum <= lim * lim) return;
    len = isqrt(sum);
    for (int k = 0; k < 3; k++) a[k] = sgn(m[k] * lim / len, a[k] < 0);
  endfunction

  function automatic void steer(input vec_t t, input vec_t p, input vec_t v, output vec_t o);
    vec_t d, u;
    for (int k = 0; k < 3; k++) d[k] = t[k] - p[k];
    unit_of(d, u);
    for (int k = 0; k < 3; k++) o[k] = sgn(mag(u[k]) * speed / 65536, u[k] < 0) - v[k];
    clamp_len(o, force_lim);
  endfunction

  function automatic void fetch_agent(int i, output vec_t p, output vec_t v);
    for (int k = 0; k < 3; k++) begin
      p[k] = pos_st[i][k];
      v[k] = vel_st[i][k];
    end
  endfunction

  function automatic void update_agent(int i, int n, vec_t goal, u64 dt);
    vec_t p, v, q, w, diff, u, mean, tgt;
    vec_t psum = '{0, 0, 0};
    vec_t vsum = '{0, 0, 0};
    vec_t ssum = '{0, 0, 0};
    vec_t coh = '{0, 0, 0};
    vec_t ali = '{0, 0, 0};
    vec_t sep = '{0, 0, 0};
    u64 m[3];
    u64 sum, dd, r2;
    s64 np;
    int cnt;
    cnt = 0;
    r2 = radius * radius;
    fetch_agent(i, p, v);
    for (int j = 0; j < n; j++) begin
      fetch_agent(j, q, w);
      for (int k = 0; k < 3; k++) diff[k] = p[k] - q[k];
      if (prescale(diff, m, sum) != 0 || sum == 0 || sum >= r2) continue;
      dd = isqrt(sum);
      unit_of(diff, u);
      for (int k = 0; k < 3; k++) begin
        psum[k] += q[k];
        vsum[k] += w[k];
        ssum[k] += sgn((mag(u[k]) << 16) / dd, u[k] < 0);
      end
      cnt++;
    end
    if (cnt > 0) begin
      for (int k = 0; k < 3; k++) begin
        mean[k] = psum[k] / s64'(cnt);
        ali[k] = vsum[k] / s64'(cnt);
        sep[k] = ssum[k] / s64'(cnt);
      end
      steer(mean, p, v, coh);
      clamp_len(ali, force_lim);
    end
    steer(goal, p, v, tgt);
    for (int k = 0; k < 3; k++)
      v[k] += coh[k] * s64'(w_coh) / 256 + ali[k] * s64'(w_ali) / 256
            + sep[k] * s64'(w_sep) / 256 + tgt[k] * s64'(w_tgt) / 256;
    clamp_len(v, speed);
    for (int k = 0; k < 3; k++) begin
      np = p[k] + v[k] * s64'(dt) / 65536;
      if (np > 64'sd2147483647) np = 64'sd2147483647;
      if (np < -64'sd2147483648) np = -64'sd2147483648;
      pos_st[i][k] = int'(np);
      vel_st[i][k] = int'(v[k]);
    end
  endfunction

  function automatic void predict_request(flock_req_t r);
    vec_t goal;
    agent_res_t e;
    int n;
    if (!r.tick) begin
      for (int k = 0; k < 3; k++) begin
        pos_st[r.idx][k] = r.lp[k];
        vel_st[r.idx][k] = r.lv[k];
      end
      return;
    end
    n = (count > NSLOT) ? NSLOT : int'(count);
    for (int k = 0; k < 3; k++) goal[k] = r.goal[k];
    for (int i = 0; i < n; i++) begin
      update_agent(i, n, goal, u64'(r.dt));
      e[0] = i;
      for (int k = 0; k < 3; k++) begin
        e[1 + k] = pos_st[i][k];
        e[4 + k] = vel_st[i][k];
      end
      e[7] = (i == n - 1);
      agent_q.push_back(e);
    end
  endfunction

  // sink side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk) begin
    agent_res_t e;
    logic [31:0] got [8];
    string nm [8];
    nm = '{"out_index", "out_pos_x", "out_pos_y", "out_pos_z",
           "out_vel_x", "out_vel_y", "out_vel_z", "last_agent"};
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      got[0] = m_tdata[3:0];
      for (int k = 1; k < 7; k++) got[k] = m_tdata[4 + 32 * (k - 1) +: 32];
      got[7] = m_tlast;
      if (agent_q.size() == 0) begin
        $error("unexpected result, index %0d", got[0]);
        errors++;
      end else begin
        e = agent_q.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (got[k] !== e[k]) begin
            $error("%s expected %0h got %0h", nm[k], e[k], got[k]);
            errors++;
          end
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(flock_req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.tick;
    s_tdata <= {4'b0, r.dt, r.goal[2], r.goal[1], r.goal[0],
                r.lv[2], r.lv[1], r.lv[0], r.lp[2], r.lp[1], r.lp[0], r.idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(r);
    if (r.tick) n_ticks++;
    else n_loads++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (agent_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(u64 rad, u64 spd, u64 frc, u64 wc, u64 wa, u64 ws, u64 wt,
                            u64 cnt);
    u64 vals[8];
    vals = '{rad, spd, frc, wc, wa, ws, wt, cnt};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= bf_pkg::CFG_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    radius = vals[bf_pkg::CFG_RADIUS] & 64'h7FFF_FFFF;
    speed = vals[bf_pkg::CFG_MAX_SPEED] & 64'h7FFF_FFFF;
    force_lim = vals[bf_pkg::CFG_MAX_FORCE] & 64'h7FFF_FFFF;
    w_coh = vals[bf_pkg::CFG_W_COH] & 64'hFFFF;
    w_ali = vals[bf_pkg::CFG_W_ALI] & 64'hFFFF;
    w_sep = vals[bf_pkg::CFG_W_SEP] & 64'hFFFF;
    w_tgt = vals[bf_pkg::CFG_W_TGT] & 64'hFFFF;
    count = vals[bf_pkg::CFG_COUNT] & 64'h1F;
  endtask

  function automatic flock_req_t load_req(int idx, int px, int py, int pz, int vx, int vy,
                                          int vz);
    flock_req_t r;
    r = '{default: 0};
    r.idx = 4'(idx);
    r.lp = '{px, py, pz};
    r.lv = '{vx, vy, vz};
    return r;
  endfunction

  function automatic flock_req_t tick_req(int gx, int gy, int gz, int dt);
    flock_req_t r;
    r = '{default: 0};
    r.tick = 1'b1;
    r.goal = '{gx, gy, gz};
    r.dt = 16'(dt);
    return r;
  endfunction

  function automatic int rnd32();
    return int'($urandom);
  endfunction

  function automatic int near(int c, int spread);
    return c + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  task automatic test_directed();
    src_idle = 27;
    snk_stall = 27;
    // coincident pair, a far agent, a close one, extreme velocities
    send_req(load_req(0, 0, 0, 0, 0, 0, 0));
    send_req(load_req(1, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
    send_req(load_req(2, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF));
    send_req(load_req(3, 655360, 0, 0, -1, 65536, 0));
    send_req(load_req(15, -1, -1, -1, -1, -1, -1));
    wait_idle();
    write_regs(6553600, 13107200, 655360, 256, 256, 256, 256, 0);
    send_req(tick_req(0, 0, 0, 100));
    wait_idle();
    write_regs(6553600, 13107200, 655360, 256, 256, 256, 256, 4);
    send_req(tick_req(0, 0, 0, 65535));
    send_req(tick_req(pos_st[0][0], pos_st[0][1], pos_st[0][2], 0));
    send_req(tick_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 65535));
    wait_idle();
    write_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'hFFFF, 4);
    send_req(tick_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 65535));
    wait_idle();
    write_regs(0, 0, 0, 0, 0, 0, 0, 4);
    send_req(tick_req(rnd32(), rnd32(), rnd32(), 65535));
    wait_idle();
    // fill the store, then a count above the store depth
    for (int i = 4; i < 15; i++)
      send_req(load_req(i, near(0, 3276800), near(0, 3276800), near(0, 3276800),
                        near(0, 655360), near(0, 655360), near(0, 655360)));
    wait_idle();
    write_regs(6553600, 13107200, 655360, 256, 256, 256, 256, 31);
    send_req(tick_req(0, 0, 0, 6553));
    wait_idle();
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int items);
    int sent, cnt, spread, cx, cy, cz, ticks;
    bit wild;
    src_idle = idle_pct;
    snk_stall = stall_pct;
    sent = 0;
    while (sent < items) begin
      wild = ($urandom_range(3) == 0);
      cnt = ($urandom_range(9) == 0) ? 1 : int'($urandom_range(2, 4));
      if (wild)
        write_regs($urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF),
                   $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), cnt);
      else
        write_regs($urandom_range(655360, 13107200), $urandom_range(65536, 13107200),
                   $urandom_range(6553, 1310720), $urandom_range(0, 1024),
                   $urandom_range(0, 1024), $urandom_range(0, 1024),
                   $urandom_range(0, 1024), cnt);
      spread = int'(radius > 64'd2000000000 ? 64'd100000000 : radius / 2 + 1);
      cx = near(0, 32'h3FFF_FFFF);
      cy = near(0, 32'h3FFF_FFFF);
      cz = near(0, 32'h3FFF_FFFF);
      for (int i = 0; i < cnt; i++) begin
        send_req(load_req(i, near(cx, spread), near(cy, spread), near(cz, spread),
                          near(0, 1310720), near(0, 1310720), near(0, 1310720)));
        sent++;
      end
      if ($urandom_range(2) == 0) begin
        send_req(load_req($urandom_range(0, 15), rnd32(), rnd32(), rnd32(), rnd32(),
                          rnd32(), rnd32()));
        sent++;
      end
      ticks = $urandom_range(1, 3);
      for (int t = 0; t < ticks; t++) begin
        if (wild)
          send_req(tick_req(rnd32(), rnd32(), rnd32(), $urandom_range(0, 65535)));
        else
          send_req(tick_req(near(cx, spread * 4), near(cy, spread * 4),
                            near(cz, spread * 4), $urandom_range(0, 65535)));
        sent++;
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    src_idle = 0;
    snk_stall = 0;
    write_regs(6553600, 13107200, 655360, 256, 256, 256, 256, 3);
    hold_left = 20000;
    for (int t = 0; t < 3; t++) send_req(tick_req(rnd32(), rnd32(), rnd32(), 30000));
    send_req(load_req(5, rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32()));
    wait_idle();
  endtask

  initial begin
    radius = 6553600;
    speed = 13107200;
    force_lim = 655360;
    w_coh = 256;
    w_ali = 256;
    w_sep = 256;
    w_tgt = 256;
    count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 18);
    test_random(46, 0, 18);
    test_random(0, 46, 18);
    test_random(27, 27, 18);
    test_backpressure();
    if (agent_q.size() != 0) begin
      $error("%0d agent results never arrived", agent_q.size());
      errors++;
    end
    $display("Covered %0d loads and %0d ticks, %0d agent results checked,", n_loads, n_ticks,
             n_results);
    $display("across register extremes, idle/stall mixes and a long output hold-off.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
